FILE: src/kmd_pkg.sv
// shared types and constants for the key matrix debounce block
`default_nettype none
package kmd_pkg;

    // field widths
    localparam int COLUMN_W   = 2;
    localparam int LEVELS_W   = 4;
    localparam int TIME_W     = 32;
    localparam int ROW_W      = 2;
    localparam int DEBOUNCE_W = 16;

    // stream data widths, padded to whole bytes
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 40;

    // reach of the input fields
    localparam int SAMPLED_ROWS = 4;
    localparam int MAX_COLUMNS  = 4;

    // register file
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [0:0] REG_DEBOUNCE_MS = 1'b0;
    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd5;

    // what one row lane found for the current item
    typedef struct packed {
        logic hit;
        logic pressed;
    } lane_evt_t;

endpackage
`default_nettype wire

FILE: src/kmd_lane.sv
// one row lane: per-column stable state, agreement time and debounce decision
`default_nettype none
module kmd_lane #(
    parameter int COL_SLOTS = 3
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              sample_en,
    input  wire logic [kmd_pkg::COLUMN_W-1:0]      column,
    input  wire logic                              raw_pressed,
    input  wire logic [kmd_pkg::TIME_W-1:0]        now_ms,
    input  wire logic [kmd_pkg::DEBOUNCE_W-1:0]    debounce_ms,
    output kmd_pkg::lane_evt_t                     evt
);

    localparam int IDX_W = (COL_SLOTS > 1) ? $clog2(COL_SLOTS) : 1;

    logic                        stable_reg [COL_SLOTS];
    logic [kmd_pkg::TIME_W-1:0]  agree_reg  [COL_SLOTS];

    logic [IDX_W-1:0]            idx;
    logic                        stable_cur;
    logic [kmd_pkg::TIME_W-1:0]  elapsed;
    logic                        differ;
    logic                        fire;

    assign idx        = column[IDX_W-1:0];
    assign stable_cur = stable_reg[idx];
    assign elapsed    = now_ms - agree_reg[idx];
    assign differ     = raw_pressed != stable_cur;
    assign fire       = differ
                        && (elapsed > {{(kmd_pkg::TIME_W-kmd_pkg::DEBOUNCE_W){1'b0}}, debounce_ms});

    assign evt.hit     = fire;
    assign evt.pressed = raw_pressed;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < COL_SLOTS; c++) begin
                stable_reg[c] <= 1'b0;
                agree_reg[c]  <= '0;
            end
        end else if (sample_en) begin
            if (!differ || fire) begin
                agree_reg[idx] <= now_ms;
            end
            if (fire) begin
                stable_reg[idx] <= raw_pressed;
            end
        end
    end

endmodule
`default_nettype wire

FILE: src/kmd_merge.sv
// merges lane hits and sends the events out one per cycle while m_tready is high, in row order
`default_nettype none
module kmd_merge #(
    parameter int LANE_COUNT = 4
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   load,
    input  wire kmd_pkg::lane_evt_t                     evt [LANE_COUNT],
    input  wire logic [kmd_pkg::COLUMN_W-1:0]           column,
    input  wire logic [kmd_pkg::TIME_W-1:0]             now_ms,
    output logic                                        in_ready,
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    output logic [kmd_pkg::M_DATA_W-1:0]                m_tdata,
    output logic                                        m_tuser,
    output logic                                        m_tlast
);

    // current group of events being sent
    logic [LANE_COUNT-1:0]         cur_mask_reg,  cur_mask_next;
    logic [LANE_COUNT-1:0]         cur_press_reg, cur_press_next;
    logic [kmd_pkg::COLUMN_W-1:0]  cur_col_reg,   cur_col_next;
    logic [kmd_pkg::TIME_W-1:0]    cur_time_reg,  cur_time_next;
    // one waiting group behind it
    logic                          nxt_valid_reg, nxt_valid_next;
    logic [LANE_COUNT-1:0]         nxt_mask_reg,  nxt_mask_next;
    logic [LANE_COUNT-1:0]         nxt_press_reg, nxt_press_next;
    logic [kmd_pkg::COLUMN_W-1:0]  nxt_col_reg,   nxt_col_next;
    logic [kmd_pkg::TIME_W-1:0]    nxt_time_reg,  nxt_time_next;

    logic [LANE_COUNT-1:0]         new_mask;
    logic [LANE_COUNT-1:0]         new_press;
    logic                          new_hit;
    logic [LANE_COUNT-1:0]         rest;
    logic [LANE_COUNT-1:0]         cur_after;
    logic [kmd_pkg::ROW_W-1:0]     row_sel;
    logic                          take;

    always_comb begin
        for (int i = 0; i < LANE_COUNT; i++) begin
            new_mask[i]  = evt[i].hit;
            new_press[i] = evt[i].pressed;
        end
    end

    assign new_hit = load && (|new_mask);

    // lowest pending row
    always_comb begin
        row_sel = '0;
        for (int i = LANE_COUNT - 1; i >= 0; i--) begin
            if (cur_mask_reg[i]) begin
                row_sel = kmd_pkg::ROW_W'(i);
            end
        end
    end

    assign rest      = cur_mask_reg & (cur_mask_reg - LANE_COUNT'(1));
    assign m_tvalid  = |cur_mask_reg;
    assign take      = m_tvalid && m_tready;
    assign cur_after = take ? rest : cur_mask_reg;
    assign in_ready  = !nxt_valid_reg;

    assign m_tdata = {{(kmd_pkg::M_DATA_W - kmd_pkg::TIME_W - kmd_pkg::COLUMN_W
                        - kmd_pkg::ROW_W){1'b0}},
                      cur_time_reg, cur_col_reg, row_sel};
    assign m_tuser = cur_press_reg[row_sel];
    assign m_tlast = rest == '0;

    always_comb begin
        cur_mask_next  = cur_after;
        cur_press_next = cur_press_reg;
        cur_col_next   = cur_col_reg;
        cur_time_next  = cur_time_reg;
        nxt_valid_next = nxt_valid_reg;
        nxt_mask_next  = nxt_mask_reg;
        nxt_press_next = nxt_press_reg;
        nxt_col_next   = nxt_col_reg;
        nxt_time_next  = nxt_time_reg;
        if (cur_after == '0) begin
            if (nxt_valid_reg) begin
                cur_mask_next  = nxt_mask_reg;
                cur_press_next = nxt_press_reg;
                cur_col_next   = nxt_col_reg;
                cur_time_next  = nxt_time_reg;
                nxt_valid_next = 1'b0;
            end else if (new_hit) begin
                cur_mask_next  = new_mask;
                cur_press_next = new_press;
                cur_col_next   = column;
                cur_time_next  = now_ms;
            end
        end else if (new_hit) begin
            nxt_valid_next = 1'b1;
            nxt_mask_next  = new_mask;
            nxt_press_next = new_press;
            nxt_col_next   = column;
            nxt_time_next  = now_ms;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_mask_reg  <= '0;
            nxt_valid_reg <= 1'b0;
        end else begin
            cur_mask_reg  <= cur_mask_next;
            nxt_valid_reg <= nxt_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_press_reg <= cur_press_next;
        cur_col_reg   <= cur_col_next;
        cur_time_reg  <= cur_time_next;
        nxt_mask_reg  <= nxt_mask_next;
        nxt_press_reg <= nxt_press_next;
        nxt_col_reg   <= nxt_col_next;
        nxt_time_reg  <= nxt_time_next;
    end

endmodule
`default_nettype wire

FILE: src/key_matrix_debounce_events_top.sv
// top level of the key matrix debounce block with press and release events
//
//   channel   direction  tdata / tuser / tlast
//   s_        in         column, row_levels, now_ms
//   m_        out        key_row, key_column, event_time_ms / key_pressed / last_event
//   apb       in         debounce_ms at byte address 0
//
// when an item is taken, every row lane reads its key of the chosen column,
// decides and updates its state at the accepting edge
// the events of one item leave one per cycle from the output buffer while m_tready
// is high, so an item gives 0 to 4 events at the output, one for each key it changes
// one more group of events waits behind the one being sent; s_tready drops only
// while that slot is full, so a stalled output holds back at most one item
// reset clears all keys to released with agreement time zero, debounce_ms to 5
`default_nettype none
module key_matrix_debounce_events_top #(
    parameter int ROW_COUNT    = 4,
    parameter int COLUMN_COUNT = 3
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // input items
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // [1:0] column, [5:2] row_levels, [37:6] now_ms, [39:38] zero
    input  wire logic [kmd_pkg::S_DATA_W-1:0]        s_tdata,
    // result items
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // [1:0] key_row, [3:2] key_column, [35:4] event_time_ms, [39:36] zero
    output logic [kmd_pkg::M_DATA_W-1:0]             m_tdata,
    // [0] key_pressed
    output logic                                     m_tuser,
    output logic                                     m_tlast,
    // configuration
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [kmd_pkg::CFG_ADDR_W-1:0]      paddr,
    input  wire logic [kmd_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [kmd_pkg::CFG_DATA_W-1:0]           prdata,
    output logic                                     pready
);

    // rows beyond the levels field and columns beyond the index field are never touched
    localparam int LANE_COUNT = (ROW_COUNT < kmd_pkg::SAMPLED_ROWS)
                                ? ROW_COUNT : kmd_pkg::SAMPLED_ROWS;
    localparam int COL_SLOTS  = (COLUMN_COUNT < kmd_pkg::MAX_COLUMNS)
                                ? COLUMN_COUNT : kmd_pkg::MAX_COLUMNS;

    // register file
    logic [kmd_pkg::DEBOUNCE_W-1:0] debounce_reg;
    logic                           cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg <= kmd_pkg::DEBOUNCE_RESET;
        end else if (cfg_write && (paddr[2] == kmd_pkg::REG_DEBOUNCE_MS)) begin
            debounce_reg <= pwdata[kmd_pkg::DEBOUNCE_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == kmd_pkg::REG_DEBOUNCE_MS) begin
            prdata = {{(kmd_pkg::CFG_DATA_W - kmd_pkg::DEBOUNCE_W){1'b0}}, debounce_reg};
        end
    end

    // input fields
    logic [kmd_pkg::COLUMN_W-1:0] in_column;
    logic [kmd_pkg::LEVELS_W-1:0] in_levels;
    logic [kmd_pkg::TIME_W-1:0]   in_now;
    logic                         col_ok;
    logic                         sample_en;
    logic                         merge_ready;

    assign in_column = s_tdata[1:0];
    assign in_levels = s_tdata[5:2];
    assign in_now    = s_tdata[37:6];

    // out-of-range column: item is consumed with no effect
    assign col_ok    = {1'b0, in_column} < 3'(COL_SLOTS);
    assign s_tready  = merge_ready;
    assign sample_en = s_tvalid && s_tready && col_ok;

    // one lane per sampled row, levels are active low
    kmd_pkg::lane_evt_t lane_evt [LANE_COUNT];

    for (genvar r = 0; r < LANE_COUNT; r++) begin : g_lane
        kmd_lane #(
            .COL_SLOTS(COL_SLOTS)
        ) u_lane (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .sample_en   (sample_en),
            .column      (in_column),
            .raw_pressed (~in_levels[r]),
            .now_ms      (in_now),
            .debounce_ms (debounce_reg),
            .evt         (lane_evt[r])
        );
    end

    // collect lane hits and serialize them in row order
    kmd_merge #(
        .LANE_COUNT(LANE_COUNT)
    ) u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (sample_en),
        .evt      (lane_evt),
        .column   (in_column),
        .now_ms   (in_now),
        .in_ready (merge_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
`default_nettype wire

FILE: tb/tb.sv
// self-checking bench for the key matrix debounce block: column samples in, key events out
module tb;

    localparam int ROWS        = 4;
    localparam int COLS        = 3;
    localparam int ROW_LIMIT   = (ROWS < kmd_pkg::SAMPLED_ROWS) ? ROWS : kmd_pkg::SAMPLED_ROWS;
    localparam int HOLD_CYCLES = 250;     // long output hold-off to back the block up
    localparam int SETTLE      = 12;      // quiet cycles before a register write or the end
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 68;      // counted items per random phase, six phases

    // one press or release event as it leaves the block
    typedef struct packed {
        logic                         key_pressed;
        logic [kmd_pkg::ROW_W-1:0]    key_row;
        logic [kmd_pkg::COLUMN_W-1:0] key_column;
        logic [kmd_pkg::TIME_W-1:0]   event_time_ms;
        logic                         last_event;
    } key_event_t;

    // mirror of the debounce state; turns each accepted sample into the events it must cause
    class debounce_tracker;
        bit [kmd_pkg::DEBOUNCE_W-1:0] debounce_ms;
        bit                           held_down [ROWS][COLS];
        bit [kmd_pkg::TIME_W-1:0]     agreed_at [ROWS][COLS];
        key_event_t                   pending_events[$];
        int unsigned                  mismatches;

        function new();
            debounce_ms = kmd_pkg::DEBOUNCE_RESET;
            mismatches  = 0;
            foreach (held_down[r, c]) begin
                held_down[r][c] = 1'b0;
                agreed_at[r][c] = '0;
            end
        endfunction

        function void take_sample(input bit [kmd_pkg::COLUMN_W-1:0] col,
                                  input bit [kmd_pkg::LEVELS_W-1:0] levels,
                                  input bit [kmd_pkg::TIME_W-1:0] now);
            key_event_t found[$];
            key_event_t ev;
            bit         raw;
            bit [kmd_pkg::TIME_W-1:0] elapsed;
            if (col >= COLS)
                return;
            for (int r = 0; r < ROW_LIMIT; r++) begin
                raw = ~levels[r];
                elapsed = now - agreed_at[r][col];
                if (raw == held_down[r][col]) begin
                    agreed_at[r][col] = now;
                end else if (elapsed > kmd_pkg::TIME_W'(debounce_ms)) begin
                    held_down[r][col] = raw;
                    agreed_at[r][col] = now;
                    ev.key_pressed   = raw;
                    ev.key_row       = kmd_pkg::ROW_W'(r);
                    ev.key_column    = col;
                    ev.event_time_ms = now;
                    ev.last_event    = 1'b0;
                    found.push_back(ev);
                end
            end
            if (found.size() > 0)
                found[found.size()-1].last_event = 1'b1;
            foreach (found[i])
                pending_events.push_back(found[i]);
        endfunction

        function void match_event(input key_event_t seen);
            key_event_t want;
            if (pending_events.size() == 0) begin
                $error("unexpected event: row %0d column %0d pressed %0d time %0h",
                       seen.key_row, seen.key_column, seen.key_pressed, seen.event_time_ms);
                mismatches++;
                return;
            end
            want = pending_events.pop_front();
            if (seen.key_pressed !== want.key_pressed) begin
                $error("key_pressed: expected %0d, got %0d", want.key_pressed, seen.key_pressed);
                mismatches++;
            end
            if (seen.key_row !== want.key_row) begin
                $error("key_row: expected %0d, got %0d", want.key_row, seen.key_row);
                mismatches++;
            end
            if (seen.key_column !== want.key_column) begin
                $error("key_column: expected %0d, got %0d", want.key_column, seen.key_column);
                mismatches++;
            end
            if (seen.event_time_ms !== want.event_time_ms) begin
                $error("event_time_ms: expected %0h, got %0h",
                       want.event_time_ms, seen.event_time_ms);
                mismatches++;
            end
            if (seen.last_event !== want.last_event) begin
                $error("last_event: expected %0d, got %0d", want.last_event, seen.last_event);
                mismatches++;
            end
        endfunction
    endclass

    logic                             aclk = 1'b0;
    logic                             aresetn;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [kmd_pkg::S_DATA_W-1:0]     s_tdata;
    logic                             m_tvalid;
    logic                             m_tready;
    logic [kmd_pkg::M_DATA_W-1:0]     m_tdata;
    logic                             m_tuser;
    logic                             m_tlast;
    logic                             psel;
    logic                             penable;
    logic                             pwrite;
    logic [kmd_pkg::CFG_ADDR_W-1:0]   paddr;
    logic [kmd_pkg::CFG_DATA_W-1:0]   pwdata;
    logic [kmd_pkg::CFG_DATA_W-1:0]   prdata;
    logic                             pready;

    debounce_tracker tracker = new();

    // shared between the two stream sides, plus the watchdog cycle count
    bit          idle_on = 1'b1;      // random gaps and stalls allowed
    bit          hold_off_req = 1'b0; // asks the result side for one long stall
    int unsigned cycle_count = 0;

    // stimulus state: which keys are physically held, the scan cursor and the ms clock
    bit                       key_down [ROWS][COLS];
    int                       scan_col = 0;
    bit [kmd_pkg::TIME_W-1:0] clock_ms = '0;

    key_matrix_debounce_events_top #(
        .ROW_COUNT    (ROWS),
        .COLUMN_COUNT (COLS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // offer one column sample and wait until the block takes it
    // an optional idle burst goes first; valid stays high between back-to-back items
    task automatic send_sample(input logic [kmd_pkg::COLUMN_W-1:0] col,
                               input logic [kmd_pkg::LEVELS_W-1:0] levels,
                               input logic [kmd_pkg::TIME_W-1:0] now);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, now, levels, col};
        do @(posedge aclk); while (!s_tready);
        tracker.take_sample(col, levels, now);
    endtask

    // stop offering and let every expected event drain before touching the register
    task automatic drain_events();
        s_tvalid <= 1'b0;
        while (tracker.pending_events.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // two-phase register write; the value lands at the access edge
    task automatic write_debounce(input logic [kmd_pkg::DEBOUNCE_W-1:0] value);
        drain_events();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {kmd_pkg::REG_DEBOUNCE_MS, 2'b00};
        pwdata  <= kmd_pkg::CFG_DATA_W'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        tracker.debounce_ms = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // mostly a steady column scan over keys that get pressed and released,
    // with contact bounce, samples of the unused column and stray samples mixed in
    task automatic random_phase(input int unsigned count, input int unsigned max_step);
        int unsigned                      done;
        int unsigned                      pick;
        logic [kmd_pkg::LEVELS_W-1:0]     levels;
        logic [kmd_pkg::COLUMN_W-1:0]     col;
        int                               rr;
        int                               cc;
        done = 0;
        while (done < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                // column past the matrix, must be ignored
                send_sample(kmd_pkg::COLUMN_W'(COLS), kmd_pkg::LEVELS_W'($urandom), $urandom);
            end else if (pick < 14) begin
                // stray sample: any levels at any time, often far behind the stored times
                col = kmd_pkg::COLUMN_W'($urandom_range(0, COLS - 1));
                send_sample(col, kmd_pkg::LEVELS_W'($urandom), $urandom);
                done++;
            end else begin
                if ($urandom_range(0, 3) == 0) begin
                    rr = $urandom_range(0, ROWS - 1);
                    cc = $urandom_range(0, COLS - 1);
                    key_down[rr][cc] = !key_down[rr][cc];
                end
                clock_ms += $urandom_range(0, max_step);
                col = kmd_pkg::COLUMN_W'(scan_col);
                scan_col = (scan_col + 1) % COLS;
                levels = '1;
                for (int r = 0; r < ROW_LIMIT; r++)
                    levels[r] = !key_down[r][col];
                // contact bounce on one row for this sample only
                if ($urandom_range(0, 7) == 0)
                    levels[$urandom_range(0, kmd_pkg::LEVELS_W - 1)] ^= 1'b1;
                send_sample(col, levels, clock_ms);
                done++;
            end
        end
    endtask

    // result side: checks every accepted event, stalls in random bursts and
    // once for a long stretch while the input side keeps offering
    initial begin : result_side
        int unsigned stall_left;
        int unsigned hold_left;
        logic        ready_next;
        key_event_t  seen;
        stall_left = 0;
        hold_left  = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                seen.key_pressed   = m_tuser;
                seen.key_row       = m_tdata[1:0];
                seen.key_column    = m_tdata[3:2];
                seen.event_time_ms = m_tdata[35:4];
                seen.last_event    = m_tlast;
                tracker.match_event(seen);
            end
            if (hold_off_req) begin
                hold_left    = HOLD_CYCLES;
                hold_off_req = 1'b0;
            end
            if (hold_left != 0) begin
                hold_left--;
                ready_next = 1'b0;
            end else if (stall_left != 0) begin
                stall_left--;
                ready_next = 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 15) - 1;
                ready_next = 1'b0;
            end else begin
                ready_next = 1'b1;
            end
            m_tready <= ready_next;
        end
    end

    // watchdog
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    initial begin : stimulus
        int unsigned d;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part at the reset delay of 5 ms, output held off meanwhile
        // so the four-event samples back the block up into its input
        hold_off_req = 1'b1;
        send_sample(2'd3, 4'h0, 32'h0000_0000);      // unused column, all rows low
        send_sample(2'd0, 4'h0, 32'h0000_0000);      // differs but no time has passed
        send_sample(2'd0, 4'h0, 32'h0000_0006);      // 6 > 5: four presses
        send_sample(2'd0, 4'hF, 32'h0000_000B);      // exactly the delay: nothing yet
        send_sample(2'd0, 4'hF, 32'h0000_000C);      // four releases
        send_sample(2'd1, 4'b1010, 32'hFFFF_FFF0);   // huge elapsed time: rows 0 and 2 press
        send_sample(2'd1, 4'hF, 32'h0000_0003);      // across the timer wrap: 19 ms, release
        send_sample(2'd2, 4'b0111, 32'hFFFF_FFFF);   // row 3 only
        send_sample(2'd2, 4'h0, 32'h0000_0004);      // 5 ms after the wrap: held back
        send_sample(2'd2, 4'h0, 32'h0000_0005);      // rows 0 to 2 press
        send_sample(2'd3, 4'hF, 32'hFFFF_FFFF);      // unused column, all ones
        send_sample(2'd0, 4'b0101, 32'h0000_0064);   // rows 1 and 3 press
        send_sample(2'd2, 4'hF, 32'h8000_0000);      // all four release

        clock_ms = 32'h0000_1000;
        random_phase(PHASE_ITEMS, 6);

        // zero delay: same timestamp is not enough, one ms later is
        write_debounce(16'd0);
        send_sample(2'd2, 4'hF, 32'h0000_03E8);
        send_sample(2'd2, 4'h0, 32'h0000_03E8);
        send_sample(2'd2, 4'h0, 32'h0000_03E9);
        random_phase(PHASE_ITEMS, 3);

        // longest delay, with the ms clock running through its wrap
        write_debounce(16'hFFFF);
        clock_ms = 32'hFFFF_FFFF - 32'd500000;
        random_phase(PHASE_ITEMS, 32770);

        write_debounce(16'd1);
        random_phase(PHASE_ITEMS, 3);

        d = $urandom_range(2, 300);
        write_debounce(kmd_pkg::DEBOUNCE_W'(d));
        random_phase(PHASE_ITEMS, d / 2 + 3);

        // last part runs with both sides always ready
        write_debounce(16'd20);
        idle_on = 1'b0;
        random_phase(PHASE_ITEMS, 13);

        drain_events();
        if (tracker.pending_events.size() != 0) begin
            $error("%0d expected events never came out", tracker.pending_events.size());
            tracker.mismatches++;
        end
        if (tracker.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

FILE: sim.f
src/kmd_pkg.sv
src/kmd_lane.sv
src/kmd_merge.sv
src/key_matrix_debounce_events_top.sv
tb/tb.sv
